[sv/prism_shape_function_eval_unit_defines.svh]
// Assertion macros shared by the prism shape function evaluator.
`ifndef PRISM_SHAPE_FUNCTION_EVAL_UNIT_DEFINES_SVH
`define PRISM_SHAPE_FUNCTION_EVAL_UNIT_DEFINES_SVH
// Checks that a condition implies a consequence at the same edge.
`define PSF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Checks that a condition implies a consequence at the next edge.
`define PSF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[sv/psf_pkg.sv]
package psf_pkg;
	localparam int unsigned NodesLin = 6;
	localparam int unsigned NodesQuad = 15;
	localparam int unsigned OutW = 20;

	typedef struct packed {
		logic [16:0] l1;
		logic [16:0] l2;
		logic signed [17:0] zeta;
		logic quad;
		logic [4:0] tag;
		logic lastp;
	} psf_req_t;
endpackage

[sv/psf_front.sv]
module psf_front import psf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input psf_req_t req_in,
	output logic q_valid,
	output psf_req_t q_req,
	input logic q_pop
);
	psf_req_t buf_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

[sv/psf_back.sv]
`include "prism_shape_function_eval_unit_defines.svh"
module psf_back import psf_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input psf_req_t q_req,
	output logic q_pop,
	output logic out_valid,
	output logic [4:0] point_tag,
	output logic [3:0] node_index,
	output logic signed [OutW-1:0] shape_value,
	output logic signed [OutW-1:0] deriv_l1,
	output logic signed [OutW-1:0] deriv_l2,
	output logic signed [OutW-1:0] deriv_zeta,
	output logic last_node,
	output logic last_of_set
);
	localparam int W = 48;
	// Every multiplier operand stays within this many signed bits for the 17- and 18-bit inputs.
	localparam int MW = (FRAC_BITS > 26) ? int'(FRAC_BITS) + 6 : 32;
	localparam logic signed [W-1:0] One = W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [W-1:0] Half = W'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [W-1:0] Two = W'(64'sd2 <<< FRAC_BITS);
	localparam logic signed [W-1:0] Lim = W'(64'sd5 <<< FRAC_BITS);

	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y);
		logic signed [MW-1:0] xs, ys;
		logic signed [2*MW-1:0] p;
		begin
			xs = x[MW-1:0];
			ys = y[MW-1:0];
			p = xs * ys + (2*MW)'(Half);
			fmul = W'(p >>> FRAC_BITS);
		end
	endfunction

	function automatic logic signed [OutW-1:0] sat(input logic signed [W-1:0] v);
		begin
			if (v > Lim) sat = OutW'(Lim);
			else if (v < -Lim) sat = OutW'(-Lim);
			else sat = v[OutW-1:0];
		end
	endfunction

	// Stage 1: latch the point and the node counter; products of node terms follow.
	logic act_q;
	psf_req_t cur_q;
	logic [3:0] node_q;
	logic signed [W-1:0] l1_s1, l2_s1, z_s1, a_s1, zm_s1, zp_s1, zz_s1;
	logic quad_s1;
	logic [4:0] tag_s1;
	logic lastp_s1, v_s1;
	logic [3:0] k_s1;

	logic signed [W-1:0] l1, l2, z, a, zm, zp;
	logic last_k;
	assign l1 = W'($signed({1'b0, cur_q.l1}));
	assign l2 = W'($signed({1'b0, cur_q.l2}));
	assign z = W'(cur_q.zeta);
	assign a = One - l1 - l2;
	assign zm = One - z;
	assign zp = One + z;
	assign last_k = cur_q.quad ? (node_q == 4'(NodesQuad - 1)) : (node_q == 4'(NodesLin - 1));
	assign q_pop = q_valid && (!act_q || last_k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			node_q <= 4'd0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= act_q;
			if (act_q && !last_k) begin
				node_q <= node_q + 4'd1;
			end else begin
				act_q <= q_valid;
				node_q <= 4'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_req;
		end
		l1_s1 <= l1; l2_s1 <= l2; z_s1 <= z;
		a_s1 <= a; zm_s1 <= zm; zp_s1 <= zp;
		zz_s1 <= One - fmul(z, z);
		quad_s1 <= cur_q.quad; tag_s1 <= cur_q.tag;
		lastp_s1 <= cur_q.lastp; k_s1 <= node_q;
	end

	// Stage 2: first product of each term chain, plus the linear factors.
	logic signed [W-1:0] pv_s2, p1_s2, p2_s2, pz_s2;
	logic signed [W-1:0] fv_s2, f1_s2, f2_s2;
	logic [1:0] mv_s2, m1_s2, m2_s2;
	logic quad_s2, lastp_s2, v_s2;
	logic [4:0] tag_s2;
	logic [3:0] k_s2;
	logic signed [W-1:0] mv, m1, m2, mz, xv, yv, x1, y1, x2, y2, xz, yz, fv, f1, f2;
	logic [1:0] cv, c1, c2;
	logic signed [W-1:0] nd, nz, ns, h_n;

	always_comb begin
		xv = '0; yv = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0; xz = '0; yz = '0;
		fv = '0; f1 = '0; f2 = '0;
		cv = 2'd0; c1 = 2'd0; c2 = 2'd0;
		case (k_s1)
			4'd0, 4'd3: nd = a_s1;
			4'd1, 4'd4: nd = l1_s1;
			default: nd = l2_s1;
		endcase
		nz = (k_s1 < 4'd3) ? zm_s1 : zp_s1;
		ns = (k_s1 < 4'd3) ? -z_s1 : z_s1;
		h_n = (k_s1 == 4'd0 || k_s1 == 4'd3) ? -Half : Half;
		if (!quad_s1) begin
			if (k_s1 < 4'd6) begin
				xv = Half; yv = nd; cv = 2'd2; fv = nz;
				if (k_s1 != 4'd2 && k_s1 != 4'd5) begin
					x1 = h_n; y1 = nz; c1 = 2'd1;
				end
				if (k_s1 != 4'd1 && k_s1 != 4'd4) begin
					x2 = h_n; y2 = nz; c2 = 2'd1;
				end
				xz = (k_s1 < 4'd3) ? -Half : Half; yz = nd;
			end
		end else begin
			case (k_s1)
				4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
					xv = Half; yv = nd; cv = 2'd3; fv = nz;
					x1 = h_n; y1 = nz; c1 = 2'd2;
					f1 = 4 * nd + ns - Two;
					x2 = h_n; y2 = nz; c2 = 2'd2; f2 = f1;
					if (k_s1 == 4'd2 || k_s1 == 4'd5) begin
						c1 = 2'd0;
					end
					if (k_s1 == 4'd1 || k_s1 == 4'd4) begin
						c2 = 2'd0;
					end
					xz = nd;
					case (k_s1)
						4'd0: yz = l1_s1 + l2_s1 + z_s1 - Half;
						4'd1: yz = -l1_s1 + z_s1 + Half;
						4'd2: yz = -l2_s1 + z_s1 + Half;
						4'd3: yz = -l1_s1 - l2_s1 + z_s1 + Half;
						4'd4: yz = l1_s1 + z_s1 - Half;
						default: yz = l2_s1 + z_s1 - Half;
					endcase
				end
				4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: begin
					xv = 2 * ((k_s1 == 4'd8 || k_s1 == 4'd11) ? l2_s1 : l1_s1);
					yv = (k_s1 == 4'd7 || k_s1 == 4'd10) ? l2_s1 : a_s1;
					cv = 2'd2;
					fv = (k_s1 < 4'd9) ? zm_s1 : zp_s1;
					c1 = 2'd1; c2 = 2'd1;
					xz = (k_s1 < 4'd9) ? -xv : xv; yz = yv;
					case (k_s1)
						4'd6, 4'd9: begin
							x1 = 2 * fv; y1 = One - 2 * l1_s1 - l2_s1;
							x2 = -2 * l1_s1; y2 = fv;
						end
						4'd7, 4'd10: begin
							x1 = 2 * l2_s1; y1 = fv;
							x2 = 2 * l1_s1; y2 = fv;
						end
						default: begin
							x1 = -2 * l2_s1; y1 = fv;
							x2 = 2 * fv; y2 = One - l1_s1 - 2 * l2_s1;
						end
					endcase
				end
				default: begin
					xv = (k_s1 == 4'd12) ? a_s1 : ((k_s1 == 4'd13) ? l1_s1 : l2_s1);
					yv = zz_s1; cv = 2'd1;
					x1 = (k_s1 == 4'd12) ? -zz_s1 : ((k_s1 == 4'd13) ? zz_s1 : '0);
					x2 = (k_s1 == 4'd12) ? -zz_s1 : ((k_s1 == 4'd14) ? zz_s1 : '0);
					xz = -2 * xv; yz = z_s1;
				end
			endcase
		end
		mv = fmul(xv, yv);
		m1 = (c1 == 2'd0) ? x1 : fmul(x1, y1);
		m2 = (c2 == 2'd0) ? x2 : fmul(x2, y2);
		mz = fmul(xz, yz);
		if (quad_s1 && k_s1 > 4'd11) begin
			m1 = x1; m2 = x2;
		end
		if (quad_s1 && k_s1 < 4'd6) begin
			if (k_s1 == 4'd1 || k_s1 == 4'd4) m2 = '0;
			if (k_s1 == 4'd2 || k_s1 == 4'd5) m1 = '0;
		end
		if (!quad_s1) begin
			if (k_s1 == 4'd2 || k_s1 == 4'd5) m1 = '0;
			if (k_s1 == 4'd1 || k_s1 == 4'd4) m2 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		pv_s2 <= mv; p1_s2 <= m1; p2_s2 <= m2; pz_s2 <= mz;
		fv_s2 <= fv; f1_s2 <= f1; f2_s2 <= f2;
		mv_s2 <= cv; m1_s2 <= c1; m2_s2 <= c2;
		quad_s2 <= quad_s1; tag_s2 <= tag_s1; lastp_s2 <= lastp_s1; k_s2 <= k_s1;
	end

	// Stage 3: second product.
	logic signed [W-1:0] pv_s3, p1_s3, p2_s3, pz_s3, gv_s3;
	logic [1:0] mv_s3;
	logic quad_s3, lastp_s3, v_s3;
	logic [4:0] tag_s3;
	logic [3:0] k_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		pv_s3 <= (mv_s2 >= 2'd2) ? fmul(pv_s2, fv_s2) : pv_s2;
		p1_s3 <= (m1_s2 == 2'd2) ? fmul(p1_s2, f1_s2) : p1_s2;
		p2_s3 <= (m2_s2 == 2'd2) ? fmul(p2_s2, f2_s2) : p2_s2;
		pz_s3 <= pz_s2;
		mv_s3 <= mv_s2;
		quad_s3 <= quad_s2; tag_s3 <= tag_s2; lastp_s3 <= lastp_s2; k_s3 <= k_s2;
	end

	// Third factor for corner nodes of the quadratic element.
	logic signed [W-1:0] lc_a_s2, lc_l1_s2, lc_l2_s2, zc_s2;
	logic signed [W-1:0] cf_s3;

	always_ff @(posedge clk) begin
		lc_a_s2 <= a_s1; lc_l1_s2 <= l1_s1; lc_l2_s2 <= l2_s1; zc_s2 <= z_s1;
	end

	function automatic logic signed [W-1:0] l_pick(input logic [3:0] k);
		begin
			case (k)
				4'd0, 4'd3: l_pick = lc_a_s2;
				4'd1, 4'd4: l_pick = lc_l1_s2;
				default: l_pick = lc_l2_s2;
			endcase
		end
	endfunction

	function automatic logic signed [W-1:0] gv_s2_calc(input logic [3:0] k);
		begin
			gv_s2_calc = (k < 4'd3) ? (2 * l_pick(k) - Two - zc_s2) :
				(2 * l_pick(k) - Two + zc_s2);
		end
	endfunction

	always_ff @(posedge clk) begin
		cf_s3 <= gv_s2_calc(k_s2);
	end
	assign gv_s3 = cf_s3;

	// Stage 4: third product and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		point_tag <= tag_s3;
		node_index <= k_s3;
		shape_value <= sat((mv_s3 == 2'd3) ? fmul(pv_s3, gv_s3) : pv_s3);
		deriv_l1 <= sat(p1_s3);
		deriv_l2 <= sat(p2_s3);
		deriv_zeta <= sat(pz_s3);
		last_node <= quad_s3 ? (k_s3 == 4'(NodesQuad - 1)) : (k_s3 == 4'(NodesLin - 1));
		last_of_set <= lastp_s3 &&
			(quad_s3 ? (k_s3 == 4'(NodesQuad - 1)) : (k_s3 == 4'(NodesLin - 1)));
	end

	`PSF_ASSERT_IMP(a_pop_needs_valid, q_pop, q_valid)
	`PSF_ASSERT_NEXT(a_node_steps, act_q && !last_k, node_q == $past(node_q) + 4'd1)
	`PSF_ASSERT_IMP(a_set_implies_last, out_valid && last_of_set, last_node)
endmodule

[sv/prism_shape_function_eval_unit.sv]
// Prism shape function evaluator for 6-node and 15-node wedge elements.
// A request is taken at a rising edge where start is high and busy is low.
// Each request carries area coordinates l1, l2, the axial coordinate zeta,
// the element order, a point index and a last-point mark.
// For each request the unit emits one result per node, 6 for the linear
// element and 15 for the quadratic one, one per cycle, each marked by a
// single-cycle valid strobe. The final node carries last_node, and
// last_of_set when the request was marked as the last point.
// A taken request passes the queue and the back-end pipeline registers.
// Sustained throughput is one node result per cycle; the nodes of a
// point are stepped by the single node sequencer in the back end.
// A two-entry request queue lets new requests enter while the back end
// works; busy rises only when that queue is full.
// Reset clears the queue and the pipeline; no results are pending after it.
// The receiver cannot stall: each result is valid for exactly one cycle.
module prism_shape_function_eval_unit import psf_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [16:0] coord_l1,
	input logic [16:0] coord_l2,
	input logic signed [17:0] coord_zeta,
	input logic quadratic,
	input logic [4:0] point_index,
	input logic last_point,
	output logic valid,
	output logic [4:0] point_tag,
	output logic [3:0] node_index,
	output logic signed [19:0] shape_value,
	output logic signed [19:0] deriv_l1,
	output logic signed [19:0] deriv_l2,
	output logic signed [19:0] deriv_zeta,
	output logic last_node,
	output logic last_of_set
);
	psf_req_t req, q_req;
	logic q_valid, q_pop;

	assign req = '{l1: coord_l1, l2: coord_l2, zeta: coord_zeta, quad: quadratic,
		tag: point_index, lastp: last_point};

	psf_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_in(req),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
	);

	psf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
		.out_valid(valid), .point_tag(point_tag), .node_index(node_index),
		.shape_value(shape_value), .deriv_l1(deriv_l1), .deriv_l2(deriv_l2),
		.deriv_zeta(deriv_zeta), .last_node(last_node), .last_of_set(last_of_set)
	);
endmodule

[tb/testbench.sv]
module testbench;
	import psf_pkg::*;

	typedef struct {
		logic [4:0] tag;
		logic [3:0] node;
		logic [19:0] val;
		logic [19:0] dl1;
		logic [19:0] dl2;
		logic [19:0] dzt;
		logic lnode;
		logic lset;
	} node_result_t;

	localparam int FB = 16;
	localparam longint ONE = 64'sd1 <<< FB;
	localparam longint HALF = 64'sd1 <<< (FB - 1);
	localparam int IDLE_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [16:0] coord_l1;
	logic [16:0] coord_l2;
	logic signed [17:0] coord_zeta;
	logic quadratic;
	logic [4:0] point_index;
	logic last_point;
	logic valid;
	logic [4:0] point_tag;
	logic [3:0] node_index;
	logic signed [19:0] shape_value;
	logic signed [19:0] deriv_l1;
	logic signed [19:0] deriv_l2;
	logic signed [19:0] deriv_zeta;
	logic last_node;
	logic last_of_set;

	node_result_t expected_nodes[$];
	int mismatches;
	int idle_cycles;
	bit timed_out;

	prism_shape_function_eval_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coord_l1(coord_l1), .coord_l2(coord_l2), .coord_zeta(coord_zeta),
		.quadratic(quadratic), .point_index(point_index), .last_point(last_point),
		.valid(valid), .point_tag(point_tag), .node_index(node_index),
		.shape_value(shape_value), .deriv_l1(deriv_l1), .deriv_l2(deriv_l2),
		.deriv_zeta(deriv_zeta), .last_node(last_node), .last_of_set(last_of_set)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint rmul(longint x, longint y);
		longint p;
		p = x * y + HALF;
		return p >>> FB;
	endfunction

	function automatic logic [19:0] clamp5(longint v);
		longint lim;
		lim = 5 * ONE;
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v[19:0];
	endfunction

	task automatic predict_nodes(input psf_req_t r);
		longint nv[15], d1[15], d2[15], dz[15];
		longint l1, l2, z, a, zm, zp, two, h, zz;
		int count;
		node_result_t e;
		l1 = longint'(r.l1);
		l2 = longint'(r.l2);
		z = longint'(r.zeta);
		a = ONE - l1 - l2;
		zm = ONE - z;
		zp = ONE + z;
		two = 2 * ONE;
		h = HALF;
		for (int k = 0; k < 15; k++) begin
			nv[k] = 0; d1[k] = 0; d2[k] = 0; dz[k] = 0;
		end
		if (!r.quad) begin
			count = int'(NodesLin);
			nv[0] = rmul(rmul(h, a), zm);
			nv[1] = rmul(rmul(h, l1), zm);
			nv[2] = rmul(rmul(h, l2), zm);
			nv[3] = rmul(rmul(h, a), zp);
			nv[4] = rmul(rmul(h, l1), zp);
			nv[5] = rmul(rmul(h, l2), zp);
			d1[0] = rmul(-h, zm); d1[1] = rmul(h, zm);
			d1[3] = rmul(-h, zp); d1[4] = rmul(h, zp);
			d2[0] = rmul(-h, zm); d2[2] = rmul(h, zm);
			d2[3] = rmul(-h, zp); d2[5] = rmul(h, zp);
			dz[0] = rmul(-h, a); dz[1] = rmul(-h, l1); dz[2] = rmul(-h, l2);
			dz[3] = rmul(h, a); dz[4] = rmul(h, l1); dz[5] = rmul(h, l2);
		end else begin
			count = int'(NodesQuad);
			zz = ONE - rmul(z, z);
			nv[0] = rmul(rmul(rmul(h, a), zm), 2 * a - two - z);
			nv[1] = rmul(rmul(rmul(h, l1), zm), 2 * l1 - two - z);
			nv[2] = rmul(rmul(rmul(h, l2), zm), 2 * l2 - two - z);
			nv[3] = rmul(rmul(rmul(h, a), zp), 2 * a - two + z);
			nv[4] = rmul(rmul(rmul(h, l1), zp), 2 * l1 - two + z);
			nv[5] = rmul(rmul(rmul(h, l2), zp), 2 * l2 - two + z);
			nv[6] = rmul(rmul(2 * l1, a), zm);
			nv[7] = rmul(rmul(2 * l1, l2), zm);
			nv[8] = rmul(rmul(2 * l2, a), zm);
			nv[9] = rmul(rmul(2 * l1, a), zp);
			nv[10] = rmul(rmul(2 * l1, l2), zp);
			nv[11] = rmul(rmul(2 * l2, a), zp);
			nv[12] = rmul(a, zz);
			nv[13] = rmul(l1, zz);
			nv[14] = rmul(l2, zz);
			d1[0] = rmul(rmul(-h, zm), 4 * a - z - two);
			d1[1] = rmul(rmul(h, zm), 4 * l1 - z - two);
			d1[3] = rmul(rmul(-h, zp), 4 * a + z - two);
			d1[4] = rmul(rmul(h, zp), 4 * l1 + z - two);
			d1[6] = rmul(2 * zm, ONE - 2 * l1 - l2);
			d1[7] = rmul(2 * l2, zm);
			d1[8] = rmul(-2 * l2, zm);
			d1[9] = rmul(2 * zp, ONE - 2 * l1 - l2);
			d1[10] = rmul(2 * l2, zp);
			d1[11] = rmul(-2 * l2, zp);
			d1[12] = -zz;
			d1[13] = zz;
			d2[0] = d1[0];
			d2[2] = rmul(rmul(h, zm), 4 * l2 - z - two);
			d2[3] = d1[3];
			d2[5] = rmul(rmul(h, zp), 4 * l2 + z - two);
			d2[6] = rmul(-2 * l1, zm);
			d2[7] = rmul(2 * l1, zm);
			d2[8] = rmul(2 * zm, ONE - l1 - 2 * l2);
			d2[9] = rmul(-2 * l1, zp);
			d2[10] = rmul(2 * l1, zp);
			d2[11] = rmul(2 * zp, ONE - l1 - 2 * l2);
			d2[12] = -zz;
			d2[14] = zz;
			dz[0] = rmul(a, l1 + l2 + z - h);
			dz[1] = rmul(l1, -l1 + z + h);
			dz[2] = rmul(l2, -l2 + z + h);
			dz[3] = rmul(a, -l1 - l2 + z + h);
			dz[4] = rmul(l1, l1 + z - h);
			dz[5] = rmul(l2, l2 + z - h);
			dz[6] = rmul(-2 * l1, a);
			dz[7] = rmul(-2 * l1, l2);
			dz[8] = rmul(-2 * l2, a);
			dz[9] = rmul(2 * l1, a);
			dz[10] = rmul(2 * l1, l2);
			dz[11] = rmul(2 * l2, a);
			dz[12] = rmul(-2 * a, z);
			dz[13] = rmul(-2 * l1, z);
			dz[14] = rmul(-2 * l2, z);
		end
		for (int k = 0; k < count; k++) begin
			e.tag = r.tag;
			e.node = k[3:0];
			e.val = clamp5(nv[k]);
			e.dl1 = clamp5(d1[k]);
			e.dl2 = clamp5(d2[k]);
			e.dzt = clamp5(dz[k]);
			e.lnode = (k == count - 1);
			e.lset = e.lnode & r.lastp;
			expected_nodes.push_back(e);
		end
	endtask

	task automatic send_point(input psf_req_t r);
		start <= 1'b1;
		coord_l1 <= r.l1;
		coord_l2 <= r.l2;
		coord_zeta <= r.zeta;
		quadratic <= r.quad;
		point_index <= r.tag;
		last_point <= r.lastp;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_nodes(r);
	endtask

	task automatic pause_sender();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 20)) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic psf_req_t random_point(bit wild);
		psf_req_t r;
		r.l1 = 17'($urandom_range(0, 65536));
		r.l2 = 17'($urandom_range(0, 65536 - int'(r.l1)));
		r.zeta = 18'($signed($urandom_range(0, 131072)) - 65536);
		if (wild) begin
			r.l1 = 17'($urandom);
			r.l2 = 17'($urandom);
			r.zeta = 18'($urandom);
		end
		r.quad = 1'($urandom);
		r.tag = 5'($urandom);
		r.lastp = 1'($urandom);
		return r;
	endfunction

	task automatic test_directed();
		psf_req_t r;
		logic [16:0] cl[4] = '{17'd0, 17'd65536, 17'd32768, 17'h1FFFF};
		logic signed [17:0] cz[4] = '{-18'sd65536, 18'sd0, 18'sd65536, -18'sd131072};
		for (int i = 0; i < 24; i++) begin
			r.l1 = cl[i % 4];
			r.l2 = cl[(i / 4) % 4];
			r.zeta = (i == 23) ? 18'sd131071 : cz[(i / 2) % 4];
			r.quad = i[0];
			r.tag = (i < 12) ? 5'd31 - i[4:0] : i[4:0];
			r.lastp = (i % 3 == 0);
			send_point(r);
		end
	endtask

	task automatic test_random_points();
		for (int i = 0; i < 300; i++) begin
			send_point(random_point($urandom_range(0, 9) == 0));
			pause_sender();
		end
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		node_result_t e;
		if (arst_n && valid) begin
			if (expected_nodes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result point %0d node %0d", point_tag, node_index);
			end else begin
				e = expected_nodes.pop_front();
				if (point_tag !== e.tag || node_index !== e.node || shape_value !== e.val
						|| deriv_l1 !== e.dl1 || deriv_l2 !== e.dl2 || deriv_zeta !== e.dzt
						|| last_node !== e.lnode || last_of_set !== e.lset) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d/%0d %h %h %h %h %b%b got %0d/%0d %h %h %h %h %b%b",
							e.tag, e.node, e.val, e.dl1, e.dl2, e.dzt, e.lnode, e.lset,
							point_tag, node_index, shape_value, deriv_l1, deriv_l2,
							deriv_zeta, last_node, last_of_set);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("prism_shape_function_eval_unit verification failed");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		coord_l1 = '0;
		coord_l2 = '0;
		coord_zeta = '0;
		quadratic = 1'b0;
		point_index = '0;
		last_point = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_points();
		while (expected_nodes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_nodes.size() == 0)
			$display("prism_shape_function_eval_unit verification clean");
		else
			$display("prism_shape_function_eval_unit verification failed");
		$finish;
	end
endmodule
